@@ rtl/gap_buffer_text_store_defines.svh @@
// Assertion macros for the gap buffer text store.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GAP_BUFFER_TEXT_STORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_DEFINES_SVH

// same-cycle implication
`define GBTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gbts_pkg.sv @@
// Package for the gap buffer text store: payload structs, codes, state enum.
// No dependencies.
`timescale 1ns / 1ps

package gbts_pkg;

	localparam int unsigned DEPTH_DEFAULT = 4096;
	localparam int unsigned POS_W         = 13;
	localparam int unsigned CHAR_W        = 8;

	typedef enum logic [2:0] {
		OP_MOVE       = 3'd0,
		OP_INSERT     = 3'd1,
		OP_DEL_BEFORE = 3'd2,
		OP_DEL_AFTER  = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_READ,
		S_HOLD
	} fsm_t;

	typedef struct packed {
		op_t                 operation;
		logic [POS_W-1:0]    position;
		logic [CHAR_W-1:0]   character;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   read_character;
		logic [POS_W-1:0]    content_length;
		logic [POS_W-1:0]    gap_position;
		status_t             status;
	} result_t;

endpackage

@@ rtl/gbts_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/gbts_core.sv @@
// Gap buffer control: gap registers, operation sequencer and the text RAM.
// Depends on gbts_pkg and gbts_ram.
`timescale 1ns / 1ps

module gbts_core #(
	parameter int unsigned BUFFER_DEPTH = gbts_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  gbts_pkg::item_t   item,
	input  logic              slot_free,
	output logic              res_valid,
	output gbts_pkg::result_t res
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned WW = (CW > gbts_pkg::POS_W) ? CW : gbts_pkg::POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	gbts_pkg::fsm_t state_q, state_d;

	logic [CW-1:0] gap_first_q, gap_after_q;
	logic [CW-1:0] span, len;
	logic [WW-1:0] pos_w, len_w, tgt_w, gf_w;
	logic [CW-1:0] tgt, pos_c, read_at;
	logic          accept, in_range, move_rd;

	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          left_q;
	logic          wr_s1;
	logic [AW-1:0] waddr_s1;

	logic [gbts_pkg::CHAR_W-1:0] rd_char_q;
	gbts_pkg::status_t           status_q;

	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [gbts_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

	assign accept   = item_valid && item_ready;
	assign span     = gap_after_q - gap_first_q;
	assign len      = DEPTH_C - span;
	assign pos_w    = WW'(item.position);
	assign len_w    = WW'(len);
	assign gf_w     = WW'(gap_first_q);
	assign tgt_w    = (pos_w > len_w) ? len_w : pos_w;
	assign tgt      = CW'(tgt_w);
	assign in_range = pos_w < len_w;
	assign pos_c    = CW'(pos_w);
	assign read_at  = (pos_c < gap_first_q) ? pos_c : pos_c + span;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbts_pkg::S_IDLE: begin
				if (accept) begin
					unique case (item.operation)
						gbts_pkg::OP_MOVE: begin
							state_d = (tgt != gap_first_q) ? gbts_pkg::S_MOVE
								: gbts_pkg::S_HOLD;
						end
						gbts_pkg::OP_READ: begin
							state_d = in_range ? gbts_pkg::S_READ : gbts_pkg::S_HOLD;
						end
						default: begin
							state_d = gbts_pkg::S_HOLD;
						end
					endcase
				end
			end
			gbts_pkg::S_MOVE: begin
				if (cnt_q == '0) begin
					state_d = gbts_pkg::S_HOLD;
				end
			end
			gbts_pkg::S_READ: begin
				state_d = gbts_pkg::S_HOLD;
			end
			gbts_pkg::S_HOLD: begin
				if (slot_free) begin
					state_d = gbts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gbts_pkg::S_IDLE;
			end
		endcase
	end

	// outputs and RAM control
	always_comb begin
		item_ready = (state_q == gbts_pkg::S_IDLE);
		res_valid  = (state_q == gbts_pkg::S_HOLD) && slot_free;
		move_rd    = (state_q == gbts_pkg::S_MOVE) && (cnt_q != '0);
		ram_re     = 1'b0;
		ram_raddr  = rd_ptr_q;
		ram_we     = 1'b0;
		ram_waddr  = waddr_s1;
		ram_wdata  = ram_rdata;
		if (move_rd) begin
			ram_re = 1'b1;
		end else if (accept && item.operation == gbts_pkg::OP_READ && in_range) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(read_at);
		end
		if (wr_s1) begin
			ram_we = 1'b1;
		end else if (accept && item.operation == gbts_pkg::OP_INSERT
				&& gap_first_q < gap_after_q) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(gap_first_q);
			ram_wdata = item.character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbts_pkg::S_IDLE;
			gap_first_q <= '0;
			gap_after_q <= DEPTH_C;
			cnt_q       <= '0;
			wr_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_s1   <= move_rd;
			if (move_rd) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (accept) begin
				unique case (item.operation)
					gbts_pkg::OP_MOVE: begin
						gap_first_q <= tgt;
						gap_after_q <= tgt + span;
						cnt_q <= (tgt < gap_first_q) ? gap_first_q - tgt : tgt - gap_first_q;
					end
					gbts_pkg::OP_INSERT: begin
						if (gap_first_q < gap_after_q) begin
							gap_first_q <= gap_first_q + CW'(1);
						end
					end
					gbts_pkg::OP_DEL_BEFORE: begin
						if (gap_first_q != '0) begin
							gap_first_q <= gap_first_q - CW'(1);
						end
					end
					gbts_pkg::OP_DEL_AFTER: begin
						if (gap_after_q != DEPTH_C) begin
							gap_after_q <= gap_after_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// copy pointers and result payload
	always_ff @(posedge clk) begin
		if (move_rd) begin
			rd_ptr_q <= left_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
			waddr_s1 <= left_q ? AW'(CW'(rd_ptr_q) + span) : AW'(CW'(rd_ptr_q) - span);
		end
		if (state_q == gbts_pkg::S_READ) begin
			rd_char_q <= ram_rdata;
		end
		if (accept) begin
			rd_char_q <= '0;
			status_q  <= gbts_pkg::ST_OK;
			unique case (item.operation)
				gbts_pkg::OP_MOVE: begin
					left_q   <= tgt < gap_first_q;
					rd_ptr_q <= (tgt < gap_first_q) ? AW'(gap_first_q - CW'(1))
						: AW'(gap_after_q);
				end
				gbts_pkg::OP_INSERT: begin
					if (gap_first_q >= gap_after_q) begin
						status_q <= gbts_pkg::ST_FULL;
					end
				end
				gbts_pkg::OP_DEL_BEFORE: begin
					if (gap_first_q == '0) begin
						status_q <= gbts_pkg::ST_EMPTY;
					end
				end
				gbts_pkg::OP_DEL_AFTER: begin
					if (gap_after_q == DEPTH_C) begin
						status_q <= gbts_pkg::ST_EMPTY;
					end
				end
				gbts_pkg::OP_READ: begin
					if (!in_range) begin
						status_q <= gbts_pkg::ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.read_character = rd_char_q;
		res.content_length = len_w[gbts_pkg::POS_W-1:0];
		res.gap_position   = gf_w[gbts_pkg::POS_W-1:0];
		res.status         = status_q;
	end

	gbts_ram #(
		.WIDTH(gbts_pkg::CHAR_W),
		.DEPTH(BUFFER_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

@@ rtl/gap_buffer_text_store.sv @@
// Gap buffer text store: the block takes one operation at a time and returns one
// result per operation. Insert, delete and out-of-range read go from transfer
// straight to the result hold; an in-range read first passes a read state, and a
// gap move copies d characters, d being the distance moved (none if already there):
// the text RAM has one read and one write port, so one character crosses the gap
// per cycle. A result waits in the output register while the next operation runs.
// Depends on gbts_pkg, gbts_core, gbts_ram and gap_buffer_text_store_defines.svh.
`timescale 1ns / 1ps
`include "gap_buffer_text_store_defines.svh"

module gap_buffer_text_store #(
	parameter int unsigned BUFFER_DEPTH = gbts_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  gbts_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output gbts_pkg::result_t result
);

	localparam logic [gbts_pkg::POS_W-1:0] DEPTH_LOW = gbts_pkg::POS_W'(BUFFER_DEPTH);

	logic              out_valid_q;
	gbts_pkg::result_t out_q;
	logic              slot_free;
	logic              res_valid;
	gbts_pkg::result_t res;

	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	gbts_core #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	`GBTS_ASSERT_NXT(a_busy_after_transfer, item_valid && item_ready, !item_ready, "ready after transfer")
	`GBTS_ASSERT_IMP(a_no_take_while_result, res_valid, !item_ready, "input taken during result")
	`GBTS_ASSERT_IMP(a_full_means_full, res_valid && res.status == gbts_pkg::ST_FULL, res.content_length == DEPTH_LOW, "full status with room left")
	`GBTS_ASSERT_IMP(a_char_zero_on_error, res_valid && res.status != gbts_pkg::ST_OK, res.read_character == '0, "character on error")

endmodule
